// ===== sv/exponential_trajectory_smoother_macros.svh =====
// ----------------------------------------------------------------------------
// Exponential trajectory smoother assertion macros
// Clocked assertion helpers shared by the smoother RTL.
// ----------------------------------------------------------------------------
`ifndef EXPONENTIAL_TRAJECTORY_SMOOTHER_MACROS_SVH
`define EXPONENTIAL_TRAJECTORY_SMOOTHER_MACROS_SVH

`ifndef SYNTH
`define ETS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("smoother assertion failed");
`define ETS_NEVER(label, expr) \
  `ETS_ASSERT(label, !(expr))
`else
`define ETS_ASSERT(label, prop)
`define ETS_NEVER(label, expr)
`endif

`endif

// ===== sv/ets_pkg.sv =====
// ----------------------------------------------------------------------------
// ets_pkg
// Shared constants, register indexes, op codes and command type.
// ----------------------------------------------------------------------------
package ets_pkg;

  localparam int LINE_DEPTH_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam int CW        = 32;
  localparam int COEF_FRAC = 28;
  localparam int CFG_IDX_W = 3;
  localparam int DLY_W     = 10;
  localparam logic [DLY_W-1:0] DLY_RESET = 10'd100;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_E     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_F     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_C     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GA    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GB    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_I     = 3'd7;

  // op code equals the sequencer step that issues it
  localparam logic [3:0] OP_P0 = 4'd0;
  localparam logic [3:0] OP_P1 = 4'd1;
  localparam logic [3:0] OP_P2 = 4'd2;
  localparam logic [3:0] OP_EP = 4'd3;
  localparam logic [3:0] OP_FP = 4'd4;
  localparam logic [3:0] OP_GA = 4'd5;
  localparam logic [3:0] OP_GB = 4'd6;
  localparam logic [3:0] OP_IQ = 4'd7;
  localparam logic [3:0] OP_EA = 4'd8;
  localparam logic [3:0] OP_FA = 4'd9;
  localparam logic [3:0] OP_GH = 4'd10;

  typedef struct packed {
    logic       load;
    logic       wr;
    logic       rd;
    logic [2:0] sel;
    logic       op;
    logic [3:0] opc;
    logic [1:0] ax;
    logic       fin;
    logic       pub;
  } cmd_t;

endpackage

// ===== sv/ets_ram.sv =====
// ----------------------------------------------------------------------------
// ets_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ets_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ets_ctrl.sv =====
// ----------------------------------------------------------------------------
// ets_ctrl
// Sequencer: sample write, six tap reads, eleven ops plus finish per axis.
// ----------------------------------------------------------------------------
module ets_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ets_pkg::cmd_t cmd_o
);
  import ets_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WRITE = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_CALC  = 3'd3;
  localparam logic [2:0] ST_PUB   = 3'd4;

  localparam logic [3:0] RD_LAST  = 4'd6;
  localparam logic [3:0] OP_LAST  = 4'd10;
  localparam logic [3:0] STEP_FIN = 4'd12;
  localparam logic [1:0] AX_LAST  = 2'd2;

  logic [2:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] ax_q, ax_d;
  logic       ov_q, ov_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ax_d       = ax_q;
    ov_d       = ov_q && !out_ready_i;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.ax   = ax_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.wr = 1'b1;
        cnt_d    = '0;
        state_d  = ST_READ;
      end
      ST_READ: begin
        if (cnt_q == RD_LAST) begin
          cnt_d   = '0;
          ax_d    = '0;
          state_d = ST_CALC;
        end else begin
          cmd_o.rd  = 1'b1;
          cmd_o.sel = cnt_q[2:0];
          cnt_d     = cnt_q + 4'd1;
        end
      end
      ST_CALC: begin
        cmd_o.op  = (cnt_q <= OP_LAST);
        cmd_o.opc = cnt_q;
        if (cnt_q == STEP_FIN) begin
          cmd_o.fin = 1'b1;
          cnt_d     = '0;
          if (ax_q == AX_LAST) begin
            state_d = ST_PUB;
          end else begin
            ax_d = ax_q + 2'd1;
          end
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      ST_PUB: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.pub = 1'b1;
          ov_d      = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ax_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ax_q    <= ax_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

endmodule

// ===== sv/ets_dpath.sv =====
// ----------------------------------------------------------------------------
// ets_dpath
// Delay line RAM, tap registers, shared multiplier, accumulators, histories.
// ----------------------------------------------------------------------------
module ets_dpath #(
  parameter int LINE_DEPTH  = ets_pkg::LINE_DEPTH_DEF,
  parameter int SAMPLE_BITS = ets_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ets_pkg::cmd_t                 cmd_i,
  input  logic                          cfg_we_i,
  input  logic [ets_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ets_pkg::CW-1:0]        cfg_data_i,
  input  logic [SAMPLE_BITS-1:0]        sample_x_i,
  input  logic [SAMPLE_BITS-1:0]        sample_y_i,
  input  logic [SAMPLE_BITS-1:0]        sample_z_i,
  output logic [SAMPLE_BITS-1:0]        pos_x_o,
  output logic [SAMPLE_BITS-1:0]        pos_y_o,
  output logic [SAMPLE_BITS-1:0]        pos_z_o,
  output logic [SAMPLE_BITS-1:0]        acc_x_o,
  output logic [SAMPLE_BITS-1:0]        acc_y_o,
  output logic [SAMPLE_BITS-1:0]        acc_z_o
);
  import ets_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int AW    = $clog2(LINE_DEPTH);
  localparam int FW    = AW + 1;
  localparam int NW    = ((AW > DLY_W) ? AW : DLY_W) + 1;
  localparam int PW    = SB + 2;
  localparam int QW    = SB + 4;
  localparam int MW    = CW + QW;
  localparam int ACC_W = SB + 52;
  localparam int LW    = 3 * SB;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC - 1);

  function automatic logic signed [ACC_W-1:0] sat(input logic signed [ACC_W-1:0] a,
                                                 input int bits);
    logic signed [ACC_W-1:0] mx;
    logic signed [ACC_W-1:0] mn;
    mx = (ACC_W'(1) << (bits - 1)) - ACC_W'(1);
    mn = ~mx;
    if (a > mx) return mx;
    if (a < mn) return mn;
    return a;
  endfunction

  // configuration
  logic [DLY_W-1:0]     dly_q;
  logic signed [CW-1:0] ce_q, cf_q, cc_q, ga_q, gb_q, gh_q, ci_q;

  // delay line control
  logic [AW-1:0] wr_q, wr_next;
  logic [FW-1:0] fill_q;
  logic [LW-1:0] smp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_q  <= DLY_RESET;
      ce_q   <= '0;
      cf_q   <= '0;
      cc_q   <= '0;
      ga_q   <= '0;
      gb_q   <= '0;
      gh_q   <= '0;
      ci_q   <= '0;
      wr_q   <= '0;
      fill_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DELAY: begin
            dly_q  <= cfg_data_i[DLY_W-1:0];
            wr_q   <= '0;
            fill_q <= '0;
          end
          REG_E:   ce_q <= signed'(cfg_data_i);
          REG_F:   cf_q <= signed'(cfg_data_i);
          REG_C:   cc_q <= signed'(cfg_data_i);
          REG_GA:  ga_q <= signed'(cfg_data_i);
          REG_GB:  gb_q <= signed'(cfg_data_i);
          REG_GH:  gh_q <= signed'(cfg_data_i);
          REG_I:   ci_q <= signed'(cfg_data_i);
          default: ;
        endcase
      end else if (cmd_i.wr) begin
        wr_q <= wr_next;
        if (fill_q != FW'(LINE_DEPTH)) begin
          fill_q <= fill_q + FW'(1);
        end
      end
    end
  end

  assign wr_next = (wr_q == AW'(LINE_DEPTH - 1)) ? '0 : wr_q + AW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      smp_q <= {sample_z_i, sample_y_i, sample_x_i};
    end
  end

  // effective window length, clamped to 1..LINE_DEPTH-3
  logic [NW-1:0] dl_w;
  logic [AW-1:0] n_c;

  always_comb begin
    dl_w = NW'(dly_q);
    if (dl_w == '0) begin
      n_c = AW'(1);
    end else if (dl_w > NW'(LINE_DEPTH - 3)) begin
      n_c = AW'(LINE_DEPTH - 3);
    end else begin
      n_c = dl_w[AW-1:0];
    end
  end

  // tap reads
  logic [AW-1:0] age_c, raddr_c;
  logic [FW-1:0] dif_c;
  logic          ok_c;
  logic [LW-1:0] rdata;
  logic          rd_vld_q, rd_ok_q;
  logic [2:0]    rd_sel_q;
  logic [LW-1:0] tap_q [6];

  always_comb begin
    if (cmd_i.sel < 3'd3) begin
      age_c = AW'(cmd_i.sel);
    end else begin
      age_c = n_c + AW'(cmd_i.sel - 3'd3);
    end
    if (wr_q >= age_c) begin
      dif_c = FW'(wr_q) - FW'(age_c);
    end else begin
      dif_c = FW'(wr_q) + FW'(LINE_DEPTH) - FW'(age_c);
    end
    raddr_c = dif_c[AW-1:0];
    ok_c    = FW'(age_c) < fill_q;
  end

  ets_ram #(
    .WIDTH (LW),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (wr_next),
    .wdata_i (smp_q),
    .raddr_i (raddr_c),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_sel_q <= cmd_i.sel;
    rd_ok_q  <= ok_c;
    if (rd_vld_q) begin
      tap_q[rd_sel_q] <= rd_ok_q ? rdata : '0;
    end
  end

  // per-axis tap values
  logic signed [SB-1:0] tv [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      tv[k] = signed'(tap_q[k][cmd_i.ax*SB +: SB]);
    end
  end

  // histories and results
  logic signed [SB-1:0] ph0_q [3];
  logic signed [SB-1:0] ph1_q [3];
  logic signed [SB-1:0] ah0_q [3];
  logic signed [SB-1:0] ah1_q [3];
  logic signed [SB-1:0] rp_q [3];
  logic signed [SB-1:0] ra_q [3];
  logic [SB-1:0]        op_q [6];

  // multiplier stage
  logic signed [PW-1:0]  p0_q, p1_q, p2_q, p_d;
  logic signed [QW-1:0]  q_q, q_d;
  logic signed [CW-1:0]  ma;
  logic signed [QW-1:0]  mb;
  logic signed [MW-1:0]  prod_q;
  logic                  pv_q;
  logic [3:0]            popc_q;

  always_comb begin
    ma = cc_q;
    mb = QW'(tv[3]);
    case (cmd_i.opc)
      OP_P0: begin ma = cc_q; mb = QW'(tv[3]); end
      OP_P1: begin ma = cc_q; mb = QW'(tv[4]); end
      OP_P2: begin ma = cc_q; mb = QW'(tv[5]); end
      OP_EP: begin ma = ce_q; mb = QW'(ph1_q[cmd_i.ax]); end
      OP_FP: begin ma = cf_q; mb = QW'(ph0_q[cmd_i.ax]); end
      OP_GA: begin ma = ga_q; mb = QW'(p1_q); end
      OP_GB: begin ma = gb_q; mb = QW'(p2_q); end
      OP_IQ: begin ma = ci_q; mb = QW'(p2_q) - QW'(p1_q); end
      OP_EA: begin ma = ce_q; mb = QW'(ah1_q[cmd_i.ax]); end
      OP_FA: begin ma = cf_q; mb = QW'(ah0_q[cmd_i.ax]); end
      OP_GH: begin ma = gh_q; mb = q_q; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= cmd_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    popc_q <= cmd_i.opc;
    if (cmd_i.op) begin
      prod_q <= ma * mb;
    end
  end

  // accumulate stage
  logic signed [ACC_W-1:0] pe, rpe, ap_q, aa_q, pos_c, acc_c;
  logic signed [SB-1:0]    near_c;

  always_comb begin
    pe   = ACC_W'(prod_q);
    rpe  = (pe + HALF) >>> COEF_FRAC;
    case (popc_q)
      OP_P0:   near_c = tv[0];
      OP_P1:   near_c = tv[1];
      default: near_c = tv[2];
    endcase
    p_d   = PW'(sat(rpe + ACC_W'(near_c), PW));
    q_d   = QW'(sat(rpe + ACC_W'(p0_q) - ACC_W'(p1_q), QW));
    pos_c = sat((ap_q + HALF) >>> COEF_FRAC, SB);
    acc_c = sat((aa_q + HALF) >>> COEF_FRAC, SB);
  end

  always_ff @(posedge clk_i) begin
    if (pv_q) begin
      case (popc_q)
        OP_P0:   p0_q <= p_d;
        OP_P1:   p1_q <= p_d;
        OP_P2:   p2_q <= p_d;
        OP_EP:   ap_q <= pe;
        OP_FP:   ap_q <= ap_q - pe;
        OP_GA:   ap_q <= ap_q + pe;
        OP_GB:   ap_q <= ap_q + pe;
        OP_IQ:   q_q  <= q_d;
        OP_EA:   aa_q <= pe;
        OP_FA:   aa_q <= aa_q - pe;
        OP_GH:   aa_q <= aa_q + (pe <<< 12);
        default: ;
      endcase
    end
    if (cmd_i.fin) begin
      rp_q[cmd_i.ax] <= SB'(pos_c);
      ra_q[cmd_i.ax] <= SB'(acc_c);
    end
    if (cmd_i.pub) begin
      for (int k = 0; k < 3; k++) begin
        op_q[k]     <= rp_q[k];
        op_q[k + 3] <= ra_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        ph0_q[k] <= '0;
        ph1_q[k] <= '0;
        ah0_q[k] <= '0;
        ah1_q[k] <= '0;
      end
    end else if (cmd_i.fin) begin
      ph0_q[cmd_i.ax] <= ph1_q[cmd_i.ax];
      ph1_q[cmd_i.ax] <= SB'(pos_c);
      ah0_q[cmd_i.ax] <= ah1_q[cmd_i.ax];
      ah1_q[cmd_i.ax] <= SB'(acc_c);
    end
  end

  assign pos_x_o = op_q[0];
  assign pos_y_o = op_q[1];
  assign pos_z_o = op_q[2];
  assign acc_x_o = op_q[3];
  assign acc_y_o = op_q[4];
  assign acc_z_o = op_q[5];

endmodule

// ===== sv/exponential_trajectory_smoother.sv =====
// ----------------------------------------------------------------------------
// exponential_trajectory_smoother
// Three-axis exponential spline smoother: position and acceleration per axis.
//
//   channel   signals                                   moves
//   in        in_valid_i / in_ready_o                    one xyz sample request
//   out       out_valid_o / out_ready_i                  pos and acc, 3 axes
//   cfg       cfg_we_i, cfg_idx_i, cfg_data_i            register write
//
// Per request: one RAM write, six tap reads, then 13 steps per axis on the
// shared multiplier; no new request is taken until the result is published.
// Reset or a delay_length write empties the line through a fill count,
// no clearing pass. A waiting result does not block the next request.
// ----------------------------------------------------------------------------
`include "exponential_trajectory_smoother_macros.svh"

module exponential_trajectory_smoother #(
  parameter int LINE_DEPTH  = ets_pkg::LINE_DEPTH_DEF,
  parameter int SAMPLE_BITS = ets_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ets_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ets_pkg::CW-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [SAMPLE_BITS-1:0]        sample_x_i,
  input  logic [SAMPLE_BITS-1:0]        sample_y_i,
  input  logic [SAMPLE_BITS-1:0]        sample_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [SAMPLE_BITS-1:0]        pos_x_o,
  output logic [SAMPLE_BITS-1:0]        pos_y_o,
  output logic [SAMPLE_BITS-1:0]        pos_z_o,
  output logic [SAMPLE_BITS-1:0]        acc_x_o,
  output logic [SAMPLE_BITS-1:0]        acc_y_o,
  output logic [SAMPLE_BITS-1:0]        acc_z_o
);
  import ets_pkg::*;

  cmd_t cmd;

  ets_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  ets_dpath #(
    .LINE_DEPTH  (LINE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_x_i (sample_x_i),
    .sample_y_i (sample_y_i),
    .sample_z_i (sample_z_i),
    .pos_x_o    (pos_x_o),
    .pos_y_o    (pos_y_o),
    .pos_z_o    (pos_z_o),
    .acc_x_o    (acc_x_o),
    .acc_y_o    (acc_y_o),
    .acc_z_o    (acc_z_o)
  );

  `ETS_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o)
  `ETS_ASSERT(a_result_from_work, $rose(out_valid_o) |-> $past(!in_ready_o))
  `ETS_NEVER(a_single_cmd, !$onehot0({cmd.load, cmd.wr, cmd.rd, cmd.fin, cmd.pub}))

endmodule
